[src/mre_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the R-type execute block.
// No dependencies; used by every module under src.
package mre_pkg;

    localparam int XLEN        = 32;
    localparam int REG_COUNT   = 32;
    localparam int REG_AW      = 5;
    localparam int SHAMT_W     = 5;
    localparam int FUNCT_W     = 6;

    // Decoupling queue between decode and execute
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Function field codes
    localparam logic [FUNCT_W-1:0] FN_SLL  = 6'h00;
    localparam logic [FUNCT_W-1:0] FN_SRL  = 6'h02;
    localparam logic [FUNCT_W-1:0] FN_JR   = 6'h08;
    localparam logic [FUNCT_W-1:0] FN_ADD  = 6'h20;
    localparam logic [FUNCT_W-1:0] FN_ADDU = 6'h21;
    localparam logic [FUNCT_W-1:0] FN_SUB  = 6'h22;
    localparam logic [FUNCT_W-1:0] FN_SUBU = 6'h23;
    localparam logic [FUNCT_W-1:0] FN_AND  = 6'h24;
    localparam logic [FUNCT_W-1:0] FN_OR   = 6'h25;
    localparam logic [FUNCT_W-1:0] FN_NOR  = 6'h27;
    localparam logic [FUNCT_W-1:0] FN_SLT  = 6'h2a;
    localparam logic [FUNCT_W-1:0] FN_SLTU = 6'h2b;

    // Internal operation classes
    typedef logic [3:0] t_op;
    localparam t_op OP_ADD  = 4'd0;
    localparam t_op OP_SUB  = 4'd1;
    localparam t_op OP_AND  = 4'd2;
    localparam t_op OP_OR   = 4'd3;
    localparam t_op OP_NOR  = 4'd4;
    localparam t_op OP_SLT  = 4'd5;
    localparam t_op OP_SLTU = 4'd6;
    localparam t_op OP_SLL  = 4'd7;
    localparam t_op OP_SRL  = 4'd8;
    localparam t_op OP_JR   = 4'd9;
    localparam t_op OP_BAD  = 4'd10;

    typedef struct packed {
        logic [REG_AW-1:0]  rs;
        logic [REG_AW-1:0]  rt;
        logic [REG_AW-1:0]  rd;
        logic [SHAMT_W-1:0] shamt;
        t_op                op;
    } t_dec;

endpackage

[src/mips_r_type_execute.sv]
`timescale 1ns / 1ps
// R-type execute block top: decode front, two-beat queue, execute back.
// An accepted beat is held in the queue, then the read stage, then the output register.
// Throughput: one instruction per cycle while i_stall is low, set by the ALU and
// register file write-back with a same-edge bypass on the operand reads.
// Reset (synchronous, active low) empties the queue and pipeline, zeroes the PC
// and marks all registers unwritten so they read as zero.
module mips_r_type_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_write_enable,
    output logic [4:0]  o_write_index,
    output logic [31:0] o_write_value,
    output logic [31:0] o_next_pc,
    output logic        o_took_jump,
    output logic        o_illegal_funct
);

    logic          push, q_full, q_valid, pop;
    mre_pkg::t_dec f_dec, q_dec;

    mre_front u_front (
        .i_valid      (i_valid),
        .i_instr_word (i_instr_word),
        .o_stall      (o_stall),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_dec        (f_dec)
    );

    mre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_dec   (f_dec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_dec   (q_dec)
    );

    mre_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_dec         (q_dec),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_enable  (o_write_enable),
        .o_write_index   (o_write_index),
        .o_write_value   (o_write_value),
        .o_next_pc       (o_next_pc),
        .o_took_jump     (o_took_jump),
        .o_illegal_funct (o_illegal_funct)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("push into full queue");

    a_jump_bad_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_took_jump && o_illegal_funct))
        else $error("jump and illegal both set");

    a_no_write_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> (o_write_index != 5'd0))
        else $error("write to register zero");

    a_idle_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_illegal_funct || o_took_jump)) |->
            (!o_write_enable && o_write_index == 5'd0 && o_write_value == 32'd0))
        else $error("non-ALU beat reports a write");

endmodule

[src/mre_front.sv]
`timescale 1ns / 1ps
// Decode front end: splits the instruction word and classifies funct.
// Depends on mre_pkg; feeds mre_queue.
module mre_front (
    input  logic                    i_valid,
    input  logic [31:0]             i_instr_word,
    output logic                    o_stall,
    input  logic                    i_q_full,
    output logic                    o_push,
    output mre_pkg::t_dec           o_dec
);

    logic [mre_pkg::FUNCT_W-1:0] funct;

    assign funct   = i_instr_word[5:0];
    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    always_comb begin
        o_dec.rs    = i_instr_word[25:21];
        o_dec.rt    = i_instr_word[20:16];
        o_dec.rd    = i_instr_word[15:11];
        o_dec.shamt = i_instr_word[10:6];
        case (funct) inside
            mre_pkg::FN_ADD, mre_pkg::FN_ADDU: o_dec.op = mre_pkg::OP_ADD;
            mre_pkg::FN_SUB, mre_pkg::FN_SUBU: o_dec.op = mre_pkg::OP_SUB;
            mre_pkg::FN_AND:  o_dec.op = mre_pkg::OP_AND;
            mre_pkg::FN_OR:   o_dec.op = mre_pkg::OP_OR;
            mre_pkg::FN_NOR:  o_dec.op = mre_pkg::OP_NOR;
            mre_pkg::FN_SLT:  o_dec.op = mre_pkg::OP_SLT;
            mre_pkg::FN_SLTU: o_dec.op = mre_pkg::OP_SLTU;
            mre_pkg::FN_SLL:  o_dec.op = mre_pkg::OP_SLL;
            mre_pkg::FN_SRL:  o_dec.op = mre_pkg::OP_SRL;
            mre_pkg::FN_JR:   o_dec.op = mre_pkg::OP_JR;
            default:          o_dec.op = mre_pkg::OP_BAD;
        endcase
    end

endmodule

[src/mre_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of decoded beats between the front end and the execute side.
// Depends on mre_pkg.
module mre_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mre_pkg::t_dec   i_dec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mre_pkg::t_dec   o_dec
);

    mre_pkg::t_dec                   r_mem [mre_pkg::QUEUE_DEPTH];
    logic [mre_pkg::QUEUE_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [mre_pkg::QUEUE_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [mre_pkg::QUEUE_CW-1:0]    r_count, n_count;
    logic                            do_push, do_pop;

    localparam logic [mre_pkg::QUEUE_AW-1:0] LAST_PTR =
        mre_pkg::QUEUE_AW'(mre_pkg::QUEUE_DEPTH - 1);
    localparam logic [mre_pkg::QUEUE_CW-1:0] FULL_COUNT =
        mre_pkg::QUEUE_CW'(mre_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_dec   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_dec;
        end
    end

endmodule

[src/mre_back.sv]
`timescale 1ns / 1ps
// Execute side: register file read, ALU, write-back, PC and output register.
// Depends on mre_pkg; pops decoded beats from mre_queue.
module mre_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mre_pkg::t_dec       i_q_dec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_write_enable,
    output logic [4:0]          o_write_index,
    output logic [31:0]         o_write_value,
    output logic [31:0]         o_next_pc,
    output logic                o_took_jump,
    output logic                o_illegal_funct
);

    localparam int XL = mre_pkg::XLEN;
    localparam int AW = mre_pkg::REG_AW;

    logic [XL-1:0]          r_rf [mre_pkg::REG_COUNT];
    logic [mre_pkg::REG_COUNT-1:0] r_rf_vld;

    // read stage
    logic                   r_rv;
    mre_pkg::t_dec          r_dec;
    logic [XL-1:0]          r_a_mem, r_b_mem;
    logic                   r_a_vld, r_b_vld;
    logic                   r_a_byp, r_b_byp;
    logic [XL-1:0]          r_byp_val;
    logic [XL-1:0]          r_pc;

    // output register
    logic                   r_out_vld;
    logic                   r_we_o, r_jump_o, r_bad_o;
    logic [AW-1:0]          r_idx_o;
    logic [XL-1:0]          r_val_o, r_pc_o;

    logic                   advance, pop;
    logic [XL-1:0]          a, b, val, pc_next;
    logic                   is_alu, is_jump, is_bad, wr;

    assign advance = r_rv & (~r_out_vld | ~i_stall);
    assign pop     = i_q_valid & (~r_rv | advance);
    assign o_pop   = pop;

    // Operand select: same-edge write bypass, then never-written entries read zero
    assign a = r_a_byp ? r_byp_val : (r_a_vld ? r_a_mem : '0);
    assign b = r_b_byp ? r_byp_val : (r_b_vld ? r_b_mem : '0);

    assign is_jump = (r_dec.op == mre_pkg::OP_JR);
    assign is_bad  = (r_dec.op == mre_pkg::OP_BAD);
    assign is_alu  = ~is_jump & ~is_bad;
    assign wr      = advance & is_alu & (r_dec.rd != '0);
    assign pc_next = is_jump ? a : r_pc + 1'b1;

    always_comb begin
        case (r_dec.op)
            mre_pkg::OP_ADD:  val = a + b;
            mre_pkg::OP_SUB:  val = a - b;
            mre_pkg::OP_AND:  val = a & b;
            mre_pkg::OP_OR:   val = a | b;
            mre_pkg::OP_NOR:  val = ~(a | b);
            mre_pkg::OP_SLT:  val = XL'($signed(a) < $signed(b));
            mre_pkg::OP_SLTU: val = XL'(a < b);
            mre_pkg::OP_SLL:  val = b << r_dec.shamt;
            mre_pkg::OP_SRL:  val = b >> r_dec.shamt;
            default:          val = '0;
        endcase
    end

    // Register file storage and registered reads
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_rf[r_dec.rd] <= val;
        end
        if (pop) begin
            r_a_mem <= r_rf[i_q_dec.rs];
            r_b_mem <= r_rf[i_q_dec.rt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_rv      <= 1'b0;
            r_pc      <= '0;
            r_out_vld <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_a_byp   <= 1'b0;
            r_b_byp   <= 1'b0;
        end else begin
            if (wr) begin
                r_rf_vld[r_dec.rd] <= 1'b1;
            end
            if (pop) begin
                r_a_vld <= r_rf_vld[i_q_dec.rs];
                r_b_vld <= r_rf_vld[i_q_dec.rt];
                r_a_byp <= wr & (r_dec.rd == i_q_dec.rs);
                r_b_byp <= wr & (r_dec.rd == i_q_dec.rt);
            end
            if (pop) begin
                r_rv <= 1'b1;
            end else if (advance) begin
                r_rv <= 1'b0;
            end
            if (advance) begin
                r_pc      <= pc_next;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_dec     <= i_q_dec;
            r_byp_val <= val;
        end
        if (advance) begin
            r_we_o   <= wr;
            r_idx_o  <= is_alu ? r_dec.rd : '0;
            r_val_o  <= is_alu ? val : '0;
            r_pc_o   <= pc_next;
            r_jump_o <= is_jump;
            r_bad_o  <= is_bad;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_write_enable  = r_we_o;
    assign o_write_index   = r_idx_o;
    assign o_write_value   = r_val_o;
    assign o_next_pc       = r_pc_o;
    assign o_took_jump     = r_jump_o;
    assign o_illegal_funct = r_bad_o;

endmodule
